[hw/rtl/psb_pkg.sv]
package psb_pkg;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_ESC   = 8'h1b;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7f;
    localparam logic [7:0] CHAR_LBRK  = 8'h5b;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_TILDE = 8'h7e;

    localparam int unsigned MARK_LEN = 6;
    localparam int unsigned CNT_W    = $clog2(MARK_LEN);
    localparam logic [CNT_W-1:0] MARK_LAST = CNT_W'(MARK_LEN - 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       first_of_paste;
        logic       last_of_paste;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       end_of_output;
    } out_word_t;

    // ESC [ 2 0 0 ~ for the start marker, ESC [ 2 0 1 ~ for the end marker
    function automatic logic [7:0] mark_byte(input logic is_end, input logic [CNT_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            CNT_W'(0): b = CHAR_ESC;
            CNT_W'(1): b = CHAR_LBRK;
            CNT_W'(2): b = CHAR_TWO;
            CNT_W'(3): b = CHAR_ZERO;
            CNT_W'(4): b = is_end ? CHAR_ONE : CHAR_ZERO;
            CNT_W'(5): b = CHAR_TILDE;
            default:   b = CHAR_TILDE;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/paste_sanitize_bracket_core.sv]
// path: an accepted word passes through the work register and then the output register; a
//   result waiting at the output does not block the next input word while the work register is empty
// throughput: one result per cycle while m_ready is high, set by the single result sequencer;
//   a kept byte gives one result, a paste edge in bracketed mode adds a six-byte marker
// reset: synchronous active low aresetn clears the mode, the cr flag and all valid state
module paste_sanitize_bracket_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psb_pkg::in_word_t   s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output psb_pkg::out_word_t  m_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_word
);

    logic                       mode_reg, mode_next;
    logic                       prev_cr_reg, prev_cr_next;

    logic                       start_left_reg, start_left_next;
    logic                       byte_left_reg, byte_left_next;
    logic                       end_left_reg, end_left_next;
    logic                       bare_left_reg, bare_left_next;
    logic                       byte_end_reg, byte_end_next;
    logic [7:0]                 byte_val_reg, byte_val_next;
    logic [psb_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic                       m_valid_reg, m_valid_next;
    psb_pkg::out_word_t         m_word_reg, m_word_next;

    logic                       work_valid;
    logic                       out_load;
    logic                       advance;
    logic                       accept;
    logic                       cnt_at_last;
    logic                       adv_start, adv_byte, adv_end, adv_bare;
    logic [psb_pkg::CNT_W-1:0]  adv_cnt;
    logic                       adv_any;

    logic                       prev_eff;
    logic                       emit;
    logic [7:0]                 emit_byte;
    logic [7:0]                 c;
    psb_pkg::out_word_t         cur;

    assign cfg_ready  = 1'b1;
    assign work_valid = start_left_reg | byte_left_reg | end_left_reg | bare_left_reg;
    assign out_load   = !m_valid_reg || m_ready;
    assign advance    = work_valid && out_load;
    assign cnt_at_last = (cnt_reg == psb_pkg::MARK_LAST);

    // remaining results once the current one moves to the output
    always_comb begin
        adv_start = start_left_reg;
        adv_byte  = byte_left_reg;
        adv_end   = end_left_reg;
        adv_bare  = bare_left_reg;
        adv_cnt   = cnt_reg;
        if (start_left_reg) begin
            if (cnt_at_last) begin
                adv_start = 1'b0;
                adv_cnt   = '0;
            end else begin
                adv_cnt = cnt_reg + 1'b1;
            end
        end else if (byte_left_reg) begin
            adv_byte = 1'b0;
        end else if (end_left_reg) begin
            if (cnt_at_last) begin
                adv_end = 1'b0;
                adv_cnt = '0;
            end else begin
                adv_cnt = cnt_reg + 1'b1;
            end
        end else begin
            adv_bare = 1'b0;
        end
        adv_any = adv_start | adv_byte | adv_end | adv_bare;
    end

    assign s_ready = !work_valid || (out_load && !adv_any);
    assign accept  = s_valid && s_ready;

    // byte filter
    always_comb begin
        c         = s_word.data_byte;
        prev_eff  = s_word.first_of_paste ? 1'b0 : prev_cr_reg;
        emit      = 1'b0;
        emit_byte = 8'h00;
        if (s_word.carries_byte) begin
            if (c == psb_pkg::CHAR_LF) begin
                emit      = !prev_eff;
                emit_byte = psb_pkg::CHAR_CR;
            end else if (c == psb_pkg::CHAR_CR) begin
                emit      = 1'b1;
                emit_byte = psb_pkg::CHAR_CR;
            end else if (c == psb_pkg::CHAR_TAB) begin
                emit      = 1'b1;
                emit_byte = psb_pkg::CHAR_TAB;
            end else if (c >= psb_pkg::CHAR_SPACE && c != psb_pkg::CHAR_DEL) begin
                emit      = 1'b1;
                emit_byte = c;
            end
        end
    end

    always_comb begin
        mode_next = cfg_valid ? cfg_word : mode_reg;

        prev_cr_next    = prev_cr_reg;
        start_left_next = start_left_reg;
        byte_left_next  = byte_left_reg;
        end_left_next   = end_left_reg;
        bare_left_next  = bare_left_reg;
        byte_end_next   = byte_end_reg;
        byte_val_next   = byte_val_reg;
        cnt_next        = cnt_reg;

        if (advance) begin
            start_left_next = adv_start;
            byte_left_next  = adv_byte;
            end_left_next   = adv_end;
            bare_left_next  = adv_bare;
            cnt_next        = adv_cnt;
        end

        if (accept) begin
            if (s_word.last_of_paste) begin
                prev_cr_next = 1'b0;
            end else if (s_word.carries_byte) begin
                prev_cr_next = (c == psb_pkg::CHAR_CR);
            end else begin
                prev_cr_next = prev_eff;
            end
            start_left_next = s_word.first_of_paste && mode_reg;
            byte_left_next  = emit;
            end_left_next   = s_word.last_of_paste && mode_reg;
            bare_left_next  = s_word.last_of_paste && !mode_reg && !emit;
            byte_end_next   = s_word.last_of_paste && !mode_reg;
            byte_val_next   = emit_byte;
            cnt_next        = '0;
        end
    end

    // current result of the work register
    always_comb begin
        if (start_left_reg) begin
            cur.out_byte      = psb_pkg::mark_byte(1'b0, cnt_reg);
            cur.byte_present  = 1'b1;
            cur.end_of_output = 1'b0;
        end else if (byte_left_reg) begin
            cur.out_byte      = byte_val_reg;
            cur.byte_present  = 1'b1;
            cur.end_of_output = byte_end_reg;
        end else if (end_left_reg) begin
            cur.out_byte      = psb_pkg::mark_byte(1'b1, cnt_reg);
            cur.byte_present  = 1'b1;
            cur.end_of_output = cnt_at_last;
        end else begin
            cur.out_byte      = 8'h00;
            cur.byte_present  = 1'b0;
            cur.end_of_output = 1'b1;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        if (out_load) begin
            m_valid_next = work_valid;
            m_word_next  = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= 1'b0;
            prev_cr_reg    <= 1'b0;
            start_left_reg <= 1'b0;
            byte_left_reg  <= 1'b0;
            end_left_reg   <= 1'b0;
            bare_left_reg  <= 1'b0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            mode_reg       <= mode_next;
            prev_cr_reg    <= prev_cr_next;
            start_left_reg <= start_left_next;
            byte_left_reg  <= byte_left_next;
            end_left_reg   <= end_left_next;
            bare_left_reg  <= bare_left_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_end_reg <= byte_end_next;
        byte_val_reg <= byte_val_next;
        m_word_reg   <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !work_valid |-> s_ready)
        else $error("input stalled with empty work register");

    a_bare_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_word.byte_present) |-> m_word.end_of_output)
        else $error("bare result without end flag");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= psb_pkg::MARK_LAST)
        else $error("marker counter out of range");

    a_empty_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !adv_any && !accept) |=> !work_valid)
        else $error("work register not drained after last result");

endmodule

[sim/psb_checker.sv]
`timescale 1ns / 1ps

module psb_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  psb_pkg::in_word_t   s_word,
    input  logic                m_valid,
    input  logic                m_ready,
    input  psb_pkg::out_word_t  m_word,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_word,
    output int                  fail_count,
    output int                  pending
);

    localparam logic [47:0] OPEN_MARK =
        {psb_pkg::CHAR_ESC, psb_pkg::CHAR_LBRK, psb_pkg::CHAR_TWO,
         psb_pkg::CHAR_ZERO, psb_pkg::CHAR_ZERO, psb_pkg::CHAR_TILDE};
    localparam logic [47:0] CLOSE_MARK =
        {psb_pkg::CHAR_ESC, psb_pkg::CHAR_LBRK, psb_pkg::CHAR_TWO,
         psb_pkg::CHAR_ZERO, psb_pkg::CHAR_ONE, psb_pkg::CHAR_TILDE};

    psb_pkg::out_word_t sanitized_q[$];
    psb_pkg::out_word_t exp_w;
    logic               bracket_on;
    logic               after_cr;
    logic               bad;

    function automatic psb_pkg::out_word_t word_of(input logic [7:0] b, input logic p,
                                                   input logic e);
        psb_pkg::out_word_t w;
        w.out_byte      = b;
        w.byte_present  = p;
        w.end_of_output = e;
        return w;
    endfunction

    task automatic predict_word(input psb_pkg::in_word_t w);
        int         i;
        int         n;
        logic       emit;
        logic [7:0] o;
        n    = 0;
        emit = 1'b0;
        o    = 8'h00;
        if (w.first_of_paste) begin
            after_cr = 1'b0;
            if (bracket_on) begin
                for (i = 0; i < psb_pkg::MARK_LEN; i++) begin
                    sanitized_q.push_back(word_of(OPEN_MARK[47 - 8*i -: 8], 1'b1, 1'b0));
                    n++;
                end
            end
        end
        if (w.carries_byte) begin
            case (w.data_byte)
                psb_pkg::CHAR_LF: begin
                    emit = !after_cr;
                    o    = psb_pkg::CHAR_CR;
                end
                psb_pkg::CHAR_CR: begin
                    emit = 1'b1;
                    o    = psb_pkg::CHAR_CR;
                end
                psb_pkg::CHAR_TAB: begin
                    emit = 1'b1;
                    o    = psb_pkg::CHAR_TAB;
                end
                default: begin
                    emit = (w.data_byte >= psb_pkg::CHAR_SPACE) &&
                           (w.data_byte != psb_pkg::CHAR_DEL);
                    o    = w.data_byte;
                end
            endcase
            after_cr = (w.data_byte == psb_pkg::CHAR_CR);
            if (emit) begin
                sanitized_q.push_back(word_of(o, 1'b1, w.last_of_paste && !bracket_on));
                n++;
            end
        end
        if (w.last_of_paste) begin
            if (bracket_on) begin
                for (i = 0; i < psb_pkg::MARK_LEN; i++) begin
                    sanitized_q.push_back(word_of(CLOSE_MARK[47 - 8*i -: 8], 1'b1,
                                                  i == psb_pkg::MARK_LEN - 1));
                end
            end else if (n == 0) begin
                sanitized_q.push_back(word_of(8'h00, 1'b0, 1'b1));
            end
            after_cr = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            bracket_on = 1'b0;
            after_cr   = 1'b0;
            fail_count = 0;
            sanitized_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (sanitized_q.size() == 0) begin
                    $display("%0t: expected no word, actual out_byte %h byte_present %b %s %b",
                             $time, m_word.out_byte, m_word.byte_present,
                             "end_of_output", m_word.end_of_output);
                    fail_count++;
                end else begin
                    exp_w = sanitized_q.pop_front();
                    bad   = 1'b0;
                    if (m_word.out_byte !== exp_w.out_byte) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, exp_w.out_byte, m_word.out_byte);
                        bad = 1'b1;
                    end
                    if (m_word.byte_present !== exp_w.byte_present) begin
                        $display("%0t: byte_present expected %b actual %b",
                                 $time, exp_w.byte_present, m_word.byte_present);
                        bad = 1'b1;
                    end
                    if (m_word.end_of_output !== exp_w.end_of_output) begin
                        $display("%0t: end_of_output expected %b actual %b",
                                 $time, exp_w.end_of_output, m_word.end_of_output);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                bracket_on = cfg_word;
            end
            if (s_valid && s_ready) begin
                predict_word(s_word);
            end
        end
        pending = sanitized_q.size();
    end

endmodule

[sim/tb_paste_sanitize_bracket_core.sv]
`timescale 1ns / 1ps

module tb_paste_sanitize_bracket_core;

    localparam int RAND_ITEMS  = 370;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 10;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    psb_pkg::in_word_t  s_word;
    logic               m_valid;
    logic               m_ready;
    psb_pkg::out_word_t m_word;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_word;
    int                 fail_count;
    int                 pending;
    bit                 calm = 1'b0;
    int                 sent_items = 0;
    int                 cycles = 0;

    paste_sanitize_bracket_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_word  (cfg_word)
    );

    psb_checker chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_word     (m_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_word   (cfg_word),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side inserts a random stall, possibly none, before each word unless calm
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    function automatic psb_pkg::in_word_t mk(input logic [7:0] b, input logic has,
                                             input logic f, input logic l);
        psb_pkg::in_word_t w;
        w.data_byte      = b;
        w.carries_byte   = has;
        w.first_of_paste = f;
        w.last_of_paste  = l;
        return w;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return psb_pkg::CHAR_CR;
        if (r < 30) return psb_pkg::CHAR_LF;
        if (r < 35) return psb_pkg::CHAR_TAB;
        if (r < 42) return psb_pkg::CHAR_DEL;
        if (r < 52) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_word(input psb_pkg::in_word_t w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_word  = w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (w.carries_byte || w.first_of_paste || w.last_of_paste) begin
            sent_items++;
        end
    endtask

    task automatic send_paste(input int len, input logic open_ok, input logic close_ok);
        int   k;
        logic has;
        for (k = 0; k < len; k++) begin
            has = ($urandom_range(0, 9) != 0);
            push_word(mk(pick_byte(), has, open_ok && (k == 0), close_ok && (k == len - 1)));
        end
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    task automatic write_mode(input logic v);
        cfg_valid = 1'b1;
        cfg_word  = v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        int phase;
        int r;
        int len;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_word    = '0;
        cfg_valid = 1'b0;
        cfg_word  = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // plain mode straight out of reset
        push_word(mk(8'h41, 1'b1, 1'b1, 1'b1));
        push_word(mk(8'h00, 1'b1, 1'b1, 1'b0));
        push_word(mk(psb_pkg::CHAR_CR, 1'b1, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_LF, 1'b1, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_LF, 1'b1, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_TAB, 1'b1, 1'b0, 1'b0));
        push_word(mk(8'h1f, 1'b1, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_DEL, 1'b1, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_SPACE, 1'b1, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_TILDE, 1'b1, 1'b0, 1'b0));
        push_word(mk(8'hff, 1'b1, 1'b0, 1'b1));
        push_word(mk(8'h00, 1'b0, 1'b1, 1'b1));
        push_word(mk(8'h78, 1'b1, 1'b1, 1'b0));
        push_word(mk(8'hff, 1'b0, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_DEL, 1'b1, 1'b0, 1'b1));
        // reopen without a close, then a cr left pending across the mode change
        push_word(mk(psb_pkg::CHAR_CR, 1'b1, 1'b1, 1'b0));
        push_word(mk(psb_pkg::CHAR_LF, 1'b1, 1'b1, 1'b0));
        push_word(mk(psb_pkg::CHAR_CR, 1'b1, 1'b0, 1'b0));
        settle();
        write_mode(1'b1);
        push_word(mk(psb_pkg::CHAR_LF, 1'b1, 1'b0, 1'b1));
        push_word(mk(8'h68, 1'b1, 1'b1, 1'b0));
        push_word(mk(8'h69, 1'b1, 1'b0, 1'b1));
        push_word(mk(8'h00, 1'b0, 1'b1, 1'b1));
        push_word(mk(8'h05, 1'b1, 1'b1, 1'b1));
        push_word(mk(psb_pkg::CHAR_CR, 1'b1, 1'b1, 1'b0));
        push_word(mk(8'h00, 1'b0, 1'b0, 1'b0));
        push_word(mk(psb_pkg::CHAR_LF, 1'b1, 1'b0, 1'b0));
        push_word(mk(8'hff, 1'b1, 1'b0, 1'b1));
        settle();
        write_mode(1'b0);
        push_word(mk(psb_pkg::CHAR_TILDE, 1'b1, 1'b0, 1'b1));

        sent_items = 0;
        phase = 0;
        while (sent_items < RAND_ITEMS) begin
            settle();
            if (phase == 0) begin
                write_mode(1'b1);
            end else if (phase == 1) begin
                write_mode(1'b0);
            end else begin
                write_mode(1'($urandom_range(0, 1)));
            end
            calm = ($urandom_range(0, 2) == 0);
            repeat (12) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    len = $urandom_range(1, 4);
                end else if (r < 95) begin
                    len = $urandom_range(5, 12);
                end else begin
                    len = $urandom_range(13, 30);
                end
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    send_paste(len, 1'b1, 1'b1);
                end else if (r < 90) begin
                    push_word(mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                end else begin
                    send_paste(len, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end

        calm = 1'b0;
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
